@@ rtl/g3fw_pkg.sv @@
// Shared types, font table and glyph decoder for the 3x5 glyph framebuffer writer.
`default_nettype none

package g3fw_pkg;

	// Number of rows and scan positions of one character cell.
	localparam int GLYPH_ROWS  = 5;
	localparam int SCAN_LEN    = 20;
	localparam int GLYPH_PIXELS = 15;

	localparam logic [5:0] GLYPH_SPACE = 6'd41;
	localparam logic [1:0] SPACER_COL  = 2'd3;

	localparam logic signed [11:0] CURSOR_X_MAX = 12'sd1023;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic advance;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_empty;
		logic step_ok;
	} status_t;

	typedef logic [4:0] glyph_t [0:GLYPH_ROWS-1];

	// Font: letters, digits, then . , $ ! : space + - ? '
	localparam glyph_t FONT_ROM [0:45] = '{
		'{5'h00, 5'h07, 5'h09, 5'h09, 5'h07}, '{5'h08, 5'h08, 5'h0E, 5'h09, 5'h0E},
		'{5'h00, 5'h07, 5'h08, 5'h08, 5'h07}, '{5'h01, 5'h01, 5'h0F, 5'h09, 5'h0F},
		'{5'h00, 5'h06, 5'h0B, 5'h08, 5'h07}, '{5'h03, 5'h04, 5'h07, 5'h04, 5'h04},
		'{5'h00, 5'h07, 5'h09, 5'h07, 5'h01}, '{5'h08, 5'h08, 5'h0E, 5'h09, 5'h09},
		'{5'h04, 5'h00, 5'h04, 5'h04, 5'h04}, '{5'h01, 5'h00, 5'h01, 5'h01, 5'h06},
		'{5'h08, 5'h09, 5'h0A, 5'h0C, 5'h0A}, '{5'h04, 5'h04, 5'h04, 5'h04, 5'h03},
		'{5'h00, 5'h15, 5'h15, 5'h15, 5'h15}, '{5'h00, 5'h0C, 5'h09, 5'h09, 5'h09},
		'{5'h00, 5'h06, 5'h09, 5'h09, 5'h06}, '{5'h00, 5'h0E, 5'h09, 5'h0E, 5'h08},
		'{5'h00, 5'h07, 5'h09, 5'h07, 5'h01}, '{5'h00, 5'h05, 5'h06, 5'h04, 5'h04},
		'{5'h00, 5'h07, 5'h04, 5'h03, 5'h0E}, '{5'h04, 5'h07, 5'h04, 5'h04, 5'h03},
		'{5'h00, 5'h09, 5'h09, 5'h09, 5'h07}, '{5'h00, 5'h09, 5'h09, 5'h0A, 5'h04},
		'{5'h00, 5'h15, 5'h15, 5'h15, 5'h0A}, '{5'h00, 5'h09, 5'h04, 5'h09, 5'h09},
		'{5'h00, 5'h09, 5'h09, 5'h07, 5'h01}, '{5'h00, 5'h07, 5'h02, 5'h04, 5'h07},
		'{5'h06, 5'h09, 5'h09, 5'h09, 5'h06}, '{5'h02, 5'h06, 5'h02, 5'h02, 5'h07},
		'{5'h06, 5'h01, 5'h06, 5'h08, 5'h0F}, '{5'h0F, 5'h02, 5'h04, 5'h01, 5'h0E},
		'{5'h09, 5'h09, 5'h0F, 5'h01, 5'h01}, '{5'h0F, 5'h08, 5'h0E, 5'h01, 5'h0E},
		'{5'h06, 5'h08, 5'h0E, 5'h09, 5'h06}, '{5'h0F, 5'h01, 5'h02, 5'h04, 5'h04},
		'{5'h06, 5'h09, 5'h06, 5'h09, 5'h06}, '{5'h06, 5'h09, 5'h07, 5'h01, 5'h06},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h04}, '{5'h00, 5'h00, 5'h04, 5'h00, 5'h04},
		'{5'h04, 5'h0E, 5'h04, 5'h0B, 5'h04}, '{5'h04, 5'h04, 5'h04, 5'h00, 5'h04},
		'{5'h00, 5'h04, 5'h00, 5'h04, 5'h00}, '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h00, 5'h04, 5'h04, 5'h00, 5'h00}, '{5'h00, 5'h00, 5'h06, 5'h00, 5'h00},
		'{5'h06, 5'h01, 5'h02, 5'h00, 5'h02}, '{5'h04, 5'h04, 5'h00, 5'h00, 5'h00}
	};

	// Maps an ASCII code to its glyph; anything unknown draws as a space.
	function automatic logic [5:0] glyph_of(input logic [7:0] ch);
		logic [7:0] lc;
		logic [5:0] g;
		lc = ch;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			lc = ch + 8'h20;
		end
		if (lc >= 8'h61 && lc <= 8'h7A) begin
			g = 6'(lc - 8'h61);
		end else if (lc >= 8'h30 && lc <= 8'h39) begin
			g = 6'(lc - 8'h30) + 6'd26;
		end else begin
			case (lc)
				8'h2E:   g = 6'd36;
				8'h2C:   g = 6'd37;
				8'h24:   g = 6'd38;
				8'h21:   g = 6'd39;
				8'h3A:   g = 6'd40;
				8'h2B:   g = 6'd42;
				8'h2D:   g = 6'd43;
				8'h3F:   g = 6'd44;
				8'h27:   g = 6'd45;
				default: g = GLYPH_SPACE;
			endcase
		end
		return g;
	endfunction

endpackage

`default_nettype wire

@@ rtl/g3fw_ctrl.sv @@
// Controller state machine: accepts a character, prepares its scan and walks it.
`default_nettype none

module g3fw_ctrl
	import g3fw_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (status.scan_empty) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
			end
			ST_RUN: begin
				cmd.advance = status.scan_empty;
				cmd.step    = !status.scan_empty && status.step_ok;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/g3fw_datapath.sv @@
// Datapath: cursor, scan mask, pixel address arithmetic and the output register.
`default_nettype none

module g3fw_datapath
	import g3fw_pkg::*;
#(
	parameter int FRAME_WIDTH  = 96,
	parameter int FRAME_HEIGHT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire logic [7:0]  character,
	input  wire logic        start_req,
	input  wire logic [9:0]  x_start,
	input  wire logic [9:0]  y_start,
	input  wire logic [15:0] fg_color,
	input  wire logic [15:0] bg_color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [12:0]      pixel_address,
	output logic [15:0]      pixel_color,
	output logic             last_write
);

	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int ROW_W = $clog2(FRAME_HEIGHT);
	localparam int AW    = (ROW_W + COL_W > 13) ? ROW_W + COL_W : 13;
	localparam logic signed [11:0] W_S = 12'(FRAME_WIDTH);
	localparam logic signed [10:0] H_S = 11'(FRAME_HEIGHT);

	logic signed [10:0] cx_q;
	logic signed [9:0]  cy_q;
	logic [5:0]         glyph_q;
	logic [15:0]        fg_q;
	logic [15:0]        bg_q;
	logic               opaque_q;
	logic [SCAN_LEN-1:0] mask_q;
	logic [SCAN_LEN-1:0] set_q;
	logic [2:0]         row_q;
	logic [1:0]         col_q;
	logic               out_valid_q;
	logic [12:0]        addr_q;
	logic [15:0]        color_q;
	logic               last_q;

	// Which columns and rows of the cell lie inside the frame.
	logic [3:0]          col_ok;
	logic [GLYPH_ROWS-1:0] row_ok;
	logic [SCAN_LEN-1:0] mask_d;
	logic [SCAN_LEN-1:0] set_d;
	logic signed [11:0]  tx [0:3];
	logic signed [10:0]  ty [0:GLYPH_ROWS-1];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			tx[c]     = {cx_q[10], cx_q} + 12'(c);
			col_ok[c] = !tx[c][11] && (tx[c] < W_S);
		end
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			ty[r]     = {cy_q[9], cy_q} + 11'(r);
			row_ok[r] = !ty[r][10] && (ty[r] < H_S);
		end
		mask_d = '0;
		set_d  = '0;
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			for (int c = 0; c < 3; c++) begin
				set_d[r*3+c]  = FONT_ROM[glyph_q][r][2-c];
				mask_d[r*3+c] = col_ok[c] && row_ok[r] && (set_d[r*3+c] || opaque_q);
			end
			mask_d[GLYPH_PIXELS+r] = opaque_q && col_ok[3] && row_ok[r];
		end
	end

	// Pixel position of the scan point in hand.
	logic signed [11:0] px;
	logic signed [10:0] py;
	logic [AW-1:0]      addr_full;
	logic signed [11:0] cx_next;

	always_comb begin
		px        = {cx_q[10], cx_q} + {10'd0, col_q};
		py        = {cy_q[9], cy_q} + {8'd0, row_q};
		addr_full = AW'(py[ROW_W-1:0]) * AW'(FRAME_WIDTH) + AW'(px[COL_W-1:0]);
		cx_next   = {cx_q[10], cx_q} + 12'sd4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.load && start_req) begin
			cx_q <= {x_start[9], x_start};
			cy_q <= y_start;
		end else if (cmd.advance) begin
			cx_q <= (cx_next > CURSOR_X_MAX) ? CURSOR_X_MAX[10:0] : cx_next[10:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			glyph_q  <= glyph_of(character);
			fg_q     <= fg_color;
			bg_q     <= bg_color;
			opaque_q <= fg_color != bg_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			set_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cmd.prep) begin
			mask_q <= mask_d;
			set_q  <= set_d;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cmd.step) begin
			mask_q <= mask_q >> 1;
			set_q  <= set_q >> 1;
			if (col_q == SPACER_COL) begin
				row_q <= row_q + 3'd1;
			end else if (col_q == 2'd2) begin
				if (row_q == 3'(GLYPH_ROWS - 1)) begin
					row_q <= '0;
					col_q <= SPACER_COL;
				end else begin
					row_q <= row_q + 3'd1;
					col_q <= '0;
				end
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	logic emit;
	assign emit = cmd.step && mask_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q  <= addr_full[12:0];
			color_q <= set_q[0] ? fg_q : bg_q;
			last_q  <= mask_q[SCAN_LEN-1:1] == '0;
		end
	end

	assign status.scan_empty = mask_q == '0;
	assign status.step_ok    = !mask_q[0] || !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign pixel_color   = color_q;
	assign last_write    = last_q;

endmodule

`default_nettype wire

@@ rtl/glyph_3x5_framebuffer_writer.sv @@
// Top level of the 3x5 glyph framebuffer writer: controller plus datapath.
`default_nettype none

// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  character, start_req, x_start, y_start,
//                                           fg_color, bg_color
// output    out        out_valid / out_stall pixel_address, pixel_color, last_write
//
// A character word is taken in an idle cycle, its scan mask is built in the next cycle,
// and then one scan position of the 20-position cell is visited per cycle; a position
// that writes waits while a pending write is held in the output register by out_stall.
// The scan ends early once no further position produces a write.
// Reset clears the cursor to the origin and empties the output register; the font is
// a constant table and needs no clearing. in_stall stays high from acceptance until the
// whole scan has been walked; a stalled write holds in the output register while the
// scan waits for it.

module glyph_3x5_framebuffer_writer
	import g3fw_pkg::*;
#(
	parameter int FRAME_WIDTH  = 96,
	parameter int FRAME_HEIGHT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  character,
	input  wire logic        start_req,
	input  wire logic [9:0]  x_start,
	input  wire logic [9:0]  y_start,
	input  wire logic [15:0] fg_color,
	input  wire logic [15:0] bg_color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [12:0]      pixel_address,
	output logic [15:0]      pixel_color,
	output logic             last_write
);

	cmd_t    cmd;
	status_t status;

	// The controller sequences load, preparation, the scan and the cursor advance.
	g3fw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the cursor, the scan mask and the output register.
	g3fw_datapath #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.character     (character),
		.start_req     (start_req),
		.x_start       (x_start),
		.y_start       (y_start),
		.fg_color      (fg_color),
		.bg_color      (bg_color),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last_write    (last_write)
	);

endmodule

`default_nettype wire
